// File: rtl/core/sparse_row_compressed_element_store_assert.svh
// Assertion macros for the sparse row compressed element store.
`ifndef SPARSE_ROW_COMPRESSED_ELEMENT_STORE_ASSERT_SVH
`define SPARSE_ROW_COMPRESSED_ELEMENT_STORE_ASSERT_SVH

// Check that an antecedent implies a consequent on the next edge.
`define SRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent at the same edge.
`define SRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/srces_pkg.sv
// Package with the types, constants and codes of the sparse element store.
package srces_pkg;

  localparam int MaxNonzeros = 1024;
  localparam int MaxRows     = 256;
  localparam int MaxCols     = 1024;
  localparam int PosW        = $clog2(MaxNonzeros);
  localparam int CntW        = $clog2(MaxNonzeros + 1);
  localparam int PtrW        = $clog2(MaxRows + 1);
  localparam int ColW        = $clog2(MaxCols);

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_PLACE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  row_index;
    logic [9:0]  col_index;
    logic [63:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [1:0]  status;
    logic [10:0] nonzero_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_PTR0, S_PTR1, S_PTR2, S_SCAN_RD, S_SCAN_CHK,
    S_SHUP_RD, S_SHUP_WR, S_SHDN_RD, S_SHDN_WR, S_PTR_RD, S_PTR_WR, S_CLEAR, S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch;
    logic ptr_rd;     // read row_start at pointer address
    logic ptr_sel;    // 0: row, 1: row+1
    logic take_start;
    logic take_end;
    logic scan_inc;
    logic ent_rd_prev;  // read entry at move index-1 (up shift)
    logic ent_rd_next;  // read entry at move index+1 (down shift)
    logic ent_wr_move;
    logic move_dec;
    logic move_inc;
    logic move_init_up;
    logic move_init_dn;
    logic ent_wr_new;
    logic val_wr_found;
    logic ptr_init;
    logic ptr_step;
    logic ptr_wr_inc;
    logic ptr_wr_dec;
    logic clr_init;
    logic clr_step;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic pend_load;  // capture the finished item's status and read value
    logic [1:0] pend_status;
    logic pend_read;
    logic res_load;   // move the captured result to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic scan_more;  // scan index below end
    logic hit;
    logic past;       // column beyond target
    logic nonzero;
    logic full;
    logic up_done;
    logic dn_done;
    logic ptr_last;   // pointer index at the last row pointer
    logic [1:0] command;
  } dp_stat_t;

endpackage

// File: rtl/core/srces_datapath.sv
// Datapath of the sparse element store: stores, pointers, counters, result.
module srces_datapath (
  input  logic                clk,
  input  logic                rst,
  input  srces_pkg::in_item_t in_item,
  input  logic                cfg_we,
  input  logic                cfg_sel,
  input  logic [10:0]         cfg_data,
  input  srces_pkg::dp_cmd_t  cmd,
  output srces_pkg::dp_stat_t stat,
  output srces_pkg::out_item_t result
);
  import srces_pkg::*;

  logic [63:0]     val_mem [MaxNonzeros];
  logic [ColW-1:0] col_mem [MaxNonzeros];
  logic [CntW-1:0] ptr_mem [MaxRows+1];

  in_item_t        item;
  logic [8:0]      num_rows;
  logic [10:0]     num_cols;
  logic [CntW-1:0] entry_count;
  logic [CntW-1:0] scan, end_ptr, move;
  logic [PtrW-1:0] pidx;
  logic [CntW-1:0] ptr_q;
  logic [63:0]     val_q;
  logic [ColW-1:0] col_q;
  logic [CntW-1:0] rd_addr;
  logic [PtrW-1:0] p_addr;
  logic [9:0]      rows_eff;
  logic [11:0]     cols_eff;
  logic [63:0]     pend_read;
  logic [1:0]      pend_status;

  always_comb begin
    rows_eff = (num_rows == '0) ? 10'd1 :
               ({1'b0, num_rows} > 10'(MaxRows)) ? 10'(MaxRows) : {1'b0, num_rows};
    cols_eff = (num_cols == '0) ? 12'd1 :
               ({1'b0, num_cols} > 12'(MaxCols)) ? 12'(MaxCols) : {1'b0, num_cols};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= 9'(MaxRows);
      num_cols <= 11'(MaxCols);
    end else if (cfg_we) begin
      if (cfg_sel == CFG_ROWS) num_rows <= cfg_data[8:0];
      else                     num_cols <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item <= in_item;
  end

  // Pointer memory port address.
  always_comb begin
    if (cmd.ptr_rd) p_addr = cmd.ptr_sel ? PtrW'({1'b0, item.row_index} + 9'd1)
                                         : PtrW'(item.row_index);
    else            p_addr = pidx;
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_wr_inc)      ptr_mem[pidx] <= ptr_q + 1'b1;
    else if (cmd.ptr_wr_dec) ptr_mem[pidx] <= ptr_q - 1'b1;
    else if (cmd.clr_step)   ptr_mem[pidx] <= '0;
    ptr_q <= ptr_mem[p_addr];
  end

  // Entry memory read address.
  always_comb begin
    if (cmd.ent_rd_prev)      rd_addr = move - 1'b1;
    else if (cmd.ent_rd_next) rd_addr = move + 1'b1;
    else                      rd_addr = scan;
  end

  always_ff @(posedge clk) begin
    if (cmd.ent_wr_move) begin
      val_mem[move[PosW-1:0]] <= val_q;
      col_mem[move[PosW-1:0]] <= col_q;
    end else if (cmd.ent_wr_new || cmd.val_wr_found) begin
      val_mem[scan[PosW-1:0]] <= item.write_value;
      if (cmd.ent_wr_new) col_mem[scan[PosW-1:0]] <= item.col_index;
    end
    val_q <= val_mem[rd_addr[PosW-1:0]];
    col_q <= col_mem[rd_addr[PosW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_start) scan <= ptr_q;
    else if (cmd.scan_inc) scan <= scan + 1'b1;
    if (cmd.take_end) end_ptr <= (ptr_q > entry_count) ? entry_count : ptr_q;
    if (cmd.move_init_up) move <= entry_count;
    else if (cmd.move_init_dn) move <= scan;
    else if (cmd.move_dec) move <= move - 1'b1;
    else if (cmd.move_inc) move <= move + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_init) pidx <= '0;
    else if (cmd.ptr_init) pidx <= PtrW'({1'b0, item.row_index} + 9'd1);
    else if (cmd.ptr_step || cmd.clr_step) pidx <= pidx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) entry_count <= '0;
    else if (cmd.cnt_inc)   entry_count <= entry_count + 1'b1;
    else if (cmd.cnt_dec)   entry_count <= entry_count - 1'b1;
  end

  // Hold the finished item's result until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_read   <= cmd.pend_read ? val_q : 64'd0;
      pend_status <= cmd.pend_status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.read_value    <= pend_read;
      result.status        <= pend_status;
      result.nonzero_count <= entry_count;
    end
  end

  always_comb begin
    stat.in_range  = ({2'b0, item.row_index} < rows_eff) &&
                     ({2'b0, item.col_index} < cols_eff);
    stat.scan_more = scan < end_ptr;
    stat.hit       = col_q == item.col_index;
    stat.past      = col_q > item.col_index;
    stat.nonzero   = item.write_value[62:0] != '0;
    stat.full      = entry_count >= CntW'(MaxNonzeros);
    stat.up_done   = move == scan;
    stat.dn_done   = (move + CntW'(1)) >= entry_count;
    stat.ptr_last  = pidx == PtrW'(MaxRows);
    stat.command   = item.command;
  end

endmodule

// File: rtl/core/srces_ctrl.sv
// Controller state machine of the sparse element store.
module srces_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_fire,
  input  srces_pkg::dp_stat_t stat,
  output srces_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                res_valid
);
  import srces_pkg::*;

  state_t state, state_next;
  logic   rv, rv_next;
  logic   up, up_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      rv    <= 1'b0;
      up    <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= rv_next;
      up    <= up_next;
    end
  end

  assign busy      = state != S_IDLE;
  assign res_valid = rv;

  always_comb begin
    state_next = state;
    rv_next    = rv && !out_fire;
    up_next    = up;
    cmd        = '0;
    unique case (state)
      S_WIPE: begin
        // Sweep the row pointers to zero after reset.
        cmd.clr_step = 1'b1;
        if (stat.ptr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch  = 1'b1;
          state_next = S_PTR0;
        end
      end
      S_PTR0: begin
        if (stat.command == CMD_CLEAR) begin
          cmd.clr_init = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_CLEAR;
        end else if (stat.command == CMD_READ || stat.command == CMD_PLACE) begin
          if (!stat.in_range) begin
            cmd.pend_load   = 1'b1;
            cmd.pend_status = ST_RANGE;
            state_next      = S_DONE;
          end else begin
            cmd.ptr_rd = 1'b1;
            state_next = S_PTR1;
          end
        end else begin
          cmd.pend_load = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_PTR1: begin
        cmd.take_start = 1'b1;
        cmd.ptr_rd     = 1'b1;
        cmd.ptr_sel    = 1'b1;
        state_next     = S_PTR2;
      end
      S_PTR2: begin
        // Row end lands now; the first entry is read at the same time.
        cmd.take_end = 1'b1;
        state_next   = S_SCAN_CHK;
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        // val_q/col_q hold the entry at scan; scan_more checks scan < end.
        if (stat.scan_more && stat.hit) begin
          if (stat.command == CMD_READ) begin
            cmd.pend_load = 1'b1;
            cmd.pend_read = 1'b1;
            state_next    = S_DONE;
          end else if (stat.nonzero) begin
            cmd.val_wr_found = 1'b1;
            cmd.pend_load    = 1'b1;
            state_next       = S_DONE;
          end else begin
            cmd.move_init_dn = 1'b1;
            up_next          = 1'b0;
            state_next       = S_SHDN_RD;
          end
        end else if (stat.scan_more && !stat.past) begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SCAN_RD;
        end else begin
          if (stat.command == CMD_READ || !stat.nonzero) begin
            cmd.pend_load = 1'b1;
            state_next    = S_DONE;
          end else if (stat.full) begin
            cmd.pend_load   = 1'b1;
            cmd.pend_status = ST_FULL;
            state_next      = S_DONE;
          end else begin
            cmd.move_init_up = 1'b1;
            up_next          = 1'b1;
            state_next       = S_SHUP_RD;
          end
        end
      end
      S_SHUP_RD: begin
        if (stat.up_done) begin
          cmd.ent_wr_new = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.ptr_init   = 1'b1;
          state_next     = S_PTR_RD;
        end else begin
          cmd.ent_rd_prev = 1'b1;
          state_next      = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        cmd.ent_wr_move = 1'b1;
        cmd.move_dec    = 1'b1;
        state_next      = S_SHUP_RD;
      end
      S_SHDN_RD: begin
        if (stat.dn_done) begin
          cmd.cnt_dec  = 1'b1;
          cmd.ptr_init = 1'b1;
          state_next   = S_PTR_RD;
        end else begin
          cmd.ent_rd_next = 1'b1;
          state_next      = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        cmd.ent_wr_move = 1'b1;
        cmd.move_inc    = 1'b1;
        state_next      = S_SHDN_RD;
      end
      S_PTR_RD: begin
        // Pointer at pidx lands in ptr_q for the write-back.
        state_next = S_PTR_WR;
      end
      S_PTR_WR: begin
        if (up) cmd.ptr_wr_inc = 1'b1;
        else    cmd.ptr_wr_dec = 1'b1;
        cmd.ptr_step = 1'b1;
        if (stat.ptr_last) begin
          cmd.pend_load = 1'b1;
          state_next    = S_DONE;
        end else begin
          state_next = S_PTR_RD;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.ptr_last) begin
          cmd.pend_load = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (!rv || out_fire) begin
          cmd.res_load = 1'b1;
          rv_next      = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/sparse_row_compressed_element_store.sv
// Top level of the sparse row compressed element store.
//
// Holds a sparse matrix of 64-bit patterns in compressed-row form.
// Input channel in_valid/in_stall carries a command (read, place, clear) with
// row, column and value; each transaction produces exactly one result
// transaction on out_valid/out_stall with read value, status and entry count.
// Configuration writes (cfg_valid/cfg_ready, index 0 rows, 1 columns) are
// taken only while the controller is idle.
// A read or place first fetches the row's start and end pointers, then scans the
// row's entries up to the match or the insertion point. An insert or delete then
// shifts the later entries by one and updates every row pointer above the row; a
// clear sweeps all row pointers and the entry count to zero. Out-of-range and
// unused commands finish without a scan.
// One item at a time: the next is accepted in the cycle after a result is loaded.
// Reset restores 256 rows and 1024 columns and sweeps the 257 row pointers to
// zero, holding in_stall high until the sweep ends.
// A stalled result holds in the output register; the next item is accepted
// and runs, and its result waits in the datapath until the first is taken.
module sparse_row_compressed_element_store (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srces_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srces_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [10:0]          cfg_data
);
  import srces_pkg::*;
  `include "sparse_row_compressed_element_store_assert.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy, in_fire, out_fire;

  assign in_stall  = busy;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign cfg_ready = !busy;

  srces_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .stat, .cmd,
    .busy, .res_valid(out_valid)
  );

  srces_datapath u_dp (
    .clk, .rst, .in_item(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index), .cfg_data,
    .cmd, .stat, .result(out_data)
  );

  `SRC_ASSERT_NOW(a_no_accept_busy, busy, !in_fire)
  `SRC_ASSERT_NEXT(a_accept_busy, in_fire, busy)
  `SRC_ASSERT_NOW(a_status_code, out_valid, out_data.status != 2'd3)
  `SRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
